/* src/vec3_vector_alu_defines.svh */
// Assertion macros for the vector ALU checker.
`ifndef VEC3_VECTOR_ALU_DEFINES_SVH
`define VEC3_VECTOR_ALU_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define VVA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define VVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vva_pkg.sv */
// Types and constants shared by the vector ALU modules.
`default_nettype none
package vva_pkg;

    // Opcodes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_NEG   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_MAG   = 3'd4;
    localparam logic [2:0] OP_NORM  = 3'd5;
    localparam logic [2:0] OP_DOT   = 3'd6;
    localparam logic [2:0] OP_CROSS = 3'd7;

    // Pipeline shape: front end, root steps, divide set-up, quotient bits, output
    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 18;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + 1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } vva_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar_out;
        logic               saturated;
        logic               zero_length;
    } vva_out_t;

    // Carried alongside the root and divide pipelines
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scal;
        logic               sat;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
    } vva_side_t;

endpackage
`default_nettype wire

/* src/vec3_vector_alu.sv */
// Top level of the pipelined three-component Q16.16 vector ALU.
//
//  channel | signals             | handshake
//  --------+---------------------+---------------------------------------
//  command | start, busy, cmd    | item taken when start high, busy low
//  result  | done, result        | item valid for the one cycle done high
//
// Every item passes through the same 32 one-bit square root stages and
// the same 18 one-bit quotient stages on its way from acceptance to its
// result, so results come back in order.
// One item may enter every cycle; busy stays low.
// rst_n clears only the valid bits along the pipeline.
`default_nettype none
module vec3_vector_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire vva_pkg::vva_in_t  cmd,
    output logic                   done,
    output vva_pkg::vva_out_t      result
);
    import vva_pkg::*;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } clip_t;

    function automatic clip_t clip33(input logic signed [32:0] v);
        clip_t c;
        c.sat = (v[32] != v[31]);
        c.val = c.sat ? (v[32] ? S32_MIN : S32_MAX) : v[31:0];
        return c;
    endfunction

    // round Q32.32 to Q16.16, ties upward, then clamp
    function automatic clip_t clip_round(input logic signed [65:0] v);
        logic [65:0] t;
        clip_t       c;
        t = v + 66'sd32768;
        if (!t[65] && (|t[64:47]))
        begin
            c.val = S32_MAX;
            c.sat = 1'b1;
        end
        else if (t[65] && !(&t[64:47]))
        begin
            c.val = S32_MIN;
            c.sat = 1'b1;
        end
        else
        begin
            c.val = t[47:16];
            c.sat = 1'b0;
        end
        return c;
    endfunction

    assign busy = 1'b0;

    // stage 1: command register
    logic    vld1_reg;
    vva_in_t cmd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= cmd;
    end

    // stage 2: add/sub/negate and all products
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [31:0] pl [3];
    logic signed [31:0] pr [3];
    logic signed [31:0] ql [3];
    logic signed [31:0] qr [3];
    logic signed [32:0] lin [3];
    clip_t              lin_c [3];

    assign av = '{cmd1_reg.a_x, cmd1_reg.a_y, cmd1_reg.a_z};
    assign bv = '{cmd1_reg.b_x, cmd1_reg.b_y, cmd1_reg.b_z};
    // second cross terms: a_z*b_y, a_x*b_z, a_y*b_x
    assign ql = '{cmd1_reg.a_z, cmd1_reg.a_x, cmd1_reg.a_y};
    assign qr = '{cmd1_reg.b_y, cmd1_reg.b_z, cmd1_reg.b_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl[i] = av[i];
            pr[i] = 32'sd0;
            if (cmd1_reg.opcode == OP_SCALE)
            begin
                pr[i] = cmd1_reg.scale_factor;
            end
            else if (cmd1_reg.opcode inside {OP_MAG, OP_NORM})
            begin
                pr[i] = av[i];
            end
            else if (cmd1_reg.opcode == OP_DOT)
            begin
                pr[i] = bv[i];
            end
            else if (cmd1_reg.opcode == OP_CROSS)
            begin
                // first cross terms: a_y*b_z, a_z*b_x, a_x*b_y
                pl[i] = ql[(i + 2) % 3];
                pr[i] = qr[(i + 1) % 3];
            end

            case (cmd1_reg.opcode)
                OP_ADD:  lin[i] = {av[i][31], av[i]} + {bv[i][31], bv[i]};
                OP_SUB:  lin[i] = {av[i][31], av[i]} - {bv[i][31], bv[i]};
                OP_NEG:  lin[i] = 33'sd0 - {av[i][31], av[i]};
                default: lin[i] = 33'sd0;
            endcase
            lin_c[i] = clip33(lin[i]);
        end
    end

    logic               vld2_reg;
    logic [2:0]         op2_reg;
    logic signed [31:0] a2_reg   [3];
    clip_t              lin2_reg [3];
    logic signed [63:0] p2_reg   [3];
    logic signed [63:0] q2_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op2_reg  <= cmd1_reg.opcode;
        a2_reg   <= av;
        lin2_reg <= lin_c;
        for (int i = 0; i < 3; i++)
        begin
            p2_reg[i] <= pl[i] * pr[i];
            q2_reg[i] <= ql[i] * qr[i];
        end
    end

    // stage 3: exact sums of products (the dot sum doubles as sum of squares)
    logic               vld3_reg;
    logic [2:0]         op3_reg;
    logic signed [31:0] a3_reg   [3];
    clip_t              lin3_reg [3];
    logic signed [65:0] v3_reg   [3];
    logic signed [65:0] dot3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op3_reg  <= op2_reg;
        a3_reg   <= a2_reg;
        lin3_reg <= lin2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (op2_reg == OP_CROSS)
            begin
                v3_reg[i] <= 66'(p2_reg[i]) - 66'(q2_reg[i]);
            end
            else
            begin
                v3_reg[i] <= 66'(p2_reg[i]);
            end
        end
        dot3_reg <= 66'(p2_reg[0]) + 66'(p2_reg[1]) + 66'(p2_reg[2]);
    end

    // rounding and clamping into the side record
    clip_t     rnd_c [3];
    clip_t     dot_c;
    vva_side_t side3;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_c[i] = clip_round(v3_reg[i]);
        end
        dot_c      = clip_round(dot3_reg);
        side3      = '0;
        side3.op   = op3_reg;
        side3.a_x  = a3_reg[0];
        side3.a_y  = a3_reg[1];
        side3.a_z  = a3_reg[2];
        if (op3_reg inside {OP_ADD, OP_SUB, OP_NEG})
        begin
            side3.r_x = lin3_reg[0].val;
            side3.r_y = lin3_reg[1].val;
            side3.r_z = lin3_reg[2].val;
            side3.sat = lin3_reg[0].sat | lin3_reg[1].sat | lin3_reg[2].sat;
        end
        else if (op3_reg inside {OP_SCALE, OP_CROSS})
        begin
            side3.r_x = rnd_c[0].val;
            side3.r_y = rnd_c[1].val;
            side3.r_z = rnd_c[2].val;
            side3.sat = rnd_c[0].sat | rnd_c[1].sat | rnd_c[2].sat;
        end
        else if (op3_reg == OP_DOT)
        begin
            side3.scal = dot_c.val;
            side3.sat  = dot_c.sat;
        end
    end

    // square root pipeline
    logic        sq_vld;
    logic [63:0] sq_rem;
    logic [63:0] sq_root;
    vva_side_t   sq_side;

    vva_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld3_reg),
        .in_sum    (dot3_reg[63:0]),
        .in_side   (side3),
        .out_valid (sq_vld),
        .out_rem   (sq_rem),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // normalize divider
    logic                 dv_vld;
    logic [32:0]          dv_mag;
    logic [DIV_STEPS-1:0] dv_q [3];
    logic [2:0]           dv_neg;
    vva_side_t            dv_side;

    vva_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_vld),
        .in_rem    (sq_rem),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_vld),
        .out_mag   (dv_mag),
        .out_q     (dv_q),
        .out_neg   (dv_neg),
        .out_side  (dv_side)
    );

    // output stage
    logic               done_reg;
    vva_out_t           result_reg;
    vva_out_t           result_next;
    logic signed [31:0] qs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = dv_neg[i] ? (32'sd0 - 32'(dv_q[i])) : 32'(dv_q[i]);
        end
        result_next.r_x         = dv_side.r_x;
        result_next.r_y         = dv_side.r_y;
        result_next.r_z         = dv_side.r_z;
        result_next.scalar_out  = dv_side.scal;
        result_next.saturated   = dv_side.sat;
        result_next.zero_length = 1'b0;
        case (dv_side.op)
            OP_MAG:
            begin
                if (dv_mag[32] || dv_mag[31])
                begin
                    result_next.scalar_out = S32_MAX;
                    result_next.saturated  = 1'b1;
                end
                else
                begin
                    result_next.scalar_out = dv_mag[31:0];
                end
            end
            OP_NORM:
            begin
                if (dv_mag == 33'd0)
                begin
                    result_next.zero_length = 1'b1;
                end
                else
                begin
                    result_next.r_x = qs[0];
                    result_next.r_y = qs[1];
                    result_next.r_z = qs[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* src/vva_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vva_isqrt (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [63:0]         in_sum,
    input  wire vva_pkg::vva_side_t  in_side,
    output logic                     out_valid,
    output logic [63:0]              out_rem,
    output logic [63:0]              out_root,
    output vva_pkg::vva_side_t       out_side
);
    import vva_pkg::*;

    logic        vld_reg  [SQRT_STEPS];
    logic [63:0] rem_reg  [SQRT_STEPS];
    logic [63:0] root_reg [SQRT_STEPS];
    vva_side_t   side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic        vld_in;
        logic [63:0] rem_in;
        logic [63:0] root_in;
        logic [63:0] trial;
        vva_side_t   side_in;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_sum;
            assign root_in = 64'd0;
            assign side_in = in_side;
        end
        else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = root_in + BIT;

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        // one trial subtraction
        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in;
            if (rem_in >= trial)
            begin
                rem_reg[k]  <= rem_in - trial;
                root_reg[k] <= (root_in >> 1) + BIT;
            end
            else
            begin
                rem_reg[k]  <= rem_in;
                root_reg[k] <= root_in >> 1;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_rem   = rem_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

/* src/vva_div.sv */
// Rounds the root and divides three components by it, one quotient bit per stage.
`default_nettype none
module vva_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [63:0]            in_rem,
    input  wire logic [63:0]            in_root,
    input  wire vva_pkg::vva_side_t     in_side,
    output logic                        out_valid,
    output logic [32:0]                 out_mag,
    output logic [vva_pkg::DIV_STEPS-1:0] out_q [3],
    output logic [2:0]                  out_neg,
    output vva_pkg::vva_side_t          out_side
);
    import vva_pkg::*;

    // dividend magnitude up to about 2^48, divisor shifted by up to 17 bits
    localparam int DW = 52;

    // set-up stage
    logic [32:0]        mag_next;
    logic [33:0]        dvs_next;
    logic signed [31:0] comp [3];
    logic signed [50:0] num  [3];
    logic [50:0]        nabs [3];
    logic [DW-1:0]      dnd_next [3];
    logic [2:0]         neg_next;

    logic               p_vld_reg;
    logic [32:0]        p_mag_reg;
    logic [DW-1:0]      p_dnd_reg [3];
    logic [2:0]         p_neg_reg;
    vva_side_t          p_side_reg;

    assign comp[0] = in_side.a_x;
    assign comp[1] = in_side.a_y;
    assign comp[2] = in_side.a_z;

    // round the root to nearest, then floor division set-up per lane
    // (a negative numerator gives ~num + 2m, i.e. |num| + 2m - 1)
    always_comb
    begin
        mag_next = in_root[32:0] + {32'd0, (in_rem > in_root)};
        dvs_next = {mag_next, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            num[i]  = {{2{comp[i][31]}}, comp[i], 17'd0} + {18'd0, mag_next};
            neg_next[i] = num[i][50];
            nabs[i] = neg_next[i] ? ~num[i] : num[i];
            dnd_next[i] = {1'b0, nabs[i]} +
                          (neg_next[i] ? {18'd0, dvs_next} : 52'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_mag_reg  <= mag_next;
        p_dnd_reg  <= dnd_next;
        p_neg_reg  <= neg_next;
        p_side_reg <= in_side;
    end

    // quotient stages
    logic                 vld_reg  [DIV_STEPS];
    logic [32:0]          mag_reg  [DIV_STEPS];
    logic [DW-1:0]        dnd_reg  [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] q_reg    [DIV_STEPS][3];
    logic [2:0]           neg_reg  [DIV_STEPS];
    vva_side_t            side_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int K = DIV_STEPS - 1 - j;
        logic                 vld_in;
        logic [32:0]          mag_in;
        logic [DW-1:0]        dnd_in [3];
        logic [DIV_STEPS-1:0] q_in   [3];
        logic [2:0]           neg_in;
        vva_side_t            side_in;
        logic [DW-1:0]        shifted;

        if (j == 0) begin : g_first
            assign vld_in  = p_vld_reg;
            assign mag_in  = p_mag_reg;
            assign dnd_in  = p_dnd_reg;
            assign q_in    = '{default: '0};
            assign neg_in  = p_neg_reg;
            assign side_in = p_side_reg;
        end
        else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign mag_in  = mag_reg[j-1];
            assign dnd_in  = dnd_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign shifted = {{(DW-34){1'b0}}, mag_in, 1'b0} << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        // restoring step on each lane
        always_ff @(posedge clk)
        begin
            mag_reg[j]  <= mag_in;
            neg_reg[j]  <= neg_in;
            side_reg[j] <= side_in;
            for (int i = 0; i < 3; i++)
            begin
                if (dnd_in[i] >= shifted)
                begin
                    dnd_reg[j][i] <= dnd_in[i] - shifted;
                    q_reg[j][i]   <= q_in[i] | (DIV_STEPS'(1) << K);
                end
                else
                begin
                    dnd_reg[j][i] <= dnd_in[i];
                    q_reg[j][i]   <= q_in[i];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_mag   = mag_reg[DIV_STEPS-1];
    assign out_q     = q_reg[DIV_STEPS-1];
    assign out_neg   = neg_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

/* src/vva_checker.sv */
// Port-level checks for the vector ALU and the bind that attaches them.
`default_nettype none
`include "vec3_vector_alu_defines.svh"
module vva_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire vva_pkg::vva_in_t  cmd,
    input wire logic              done,
    input wire vva_pkg::vva_out_t result
);
    import vva_pkg::*;

    // the pipeline never holds off a command
    `VVA_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

    // every result comes from an item taken a fixed latency earlier
    `VVA_ASSERT_IMPL(a_fixed_latency, done, $past(start && !busy, LATENCY), "result without item")

    // zero-length flag only for normalize, with everything else zero
    `VVA_ASSERT_IMPL(a_zero_length, done && result.zero_length, $past(cmd.opcode == OP_NORM, LATENCY) && result.r_x == 0 && result.r_y == 0 && result.r_z == 0 && result.scalar_out == 0 && !result.saturated, "bad zero-length result")

    // a scalar result leaves the vector outputs clear
    `VVA_ASSERT_IMPL(a_scalar_excl, done && result.scalar_out != 0, result.r_x == 0 && result.r_y == 0 && result.r_z == 0, "scalar and vector both set")

endmodule

bind vec3_vector_alu vva_checker u_vva_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
`default_nettype wire
